// ===== design/arw_pkg.sv =====
`timescale 1ns / 1ps

package arw_pkg;

  localparam int PnW = 64;

  typedef enum logic [1:0] {
    VERDICT_FRESH    = 2'd0,
    VERDICT_REPLAYED = 2'd1,
    VERDICT_TOO_OLD  = 2'd2,
    VERDICT_ZERO     = 2'd3
  } verdict_t;

  typedef struct packed {
    logic     accepted;
    verdict_t verdict;
    logic     update;
  } judge_t;

endpackage

// ===== design/arw_judge.sv =====
`timescale 1ns / 1ps

module arw_judge #(
  parameter int WINDOW_SIZE = 64
) (
  input  logic                      action,
  input  logic [arw_pkg::PnW-1:0]   packet_number,
  input  logic [arw_pkg::PnW-1:0]   highest,
  input  logic [WINDOW_SIZE-1:0]    bitmap,
  output arw_pkg::judge_t           res,
  output logic [arw_pkg::PnW-1:0]   highest_next,
  output logic [WINDOW_SIZE-1:0]    bitmap_next
);
  import arw_pkg::*;

  localparam int IdxW = $clog2(WINDOW_SIZE);
  localparam logic [IdxW-1:0] TopIdx = IdxW'(WINDOW_SIZE - 1);

  logic                   ahead;
  logic                   is_zero;
  logic                   too_old;
  logic                   far_jump;
  logic                   seen;
  logic [PnW-1:0]         lag;
  logic [PnW-1:0]         diff;
  logic [IdxW-1:0]        bit_idx;
  logic [WINDOW_SIZE-1:0] mark_onehot;
  logic [WINDOW_SIZE-1:0] top_onehot;
  logic [WINDOW_SIZE-1:0] shifted;
  verdict_t               verdict;

  assign ahead    = packet_number > highest;
  assign is_zero  = packet_number == '0;
  assign lag      = highest - packet_number;
  assign diff     = packet_number - highest;
  assign too_old  = lag >= PnW'(WINDOW_SIZE);
  assign far_jump = diff >= PnW'(WINDOW_SIZE);
  assign bit_idx  = TopIdx - lag[IdxW-1:0];
  assign seen     = bitmap[bit_idx];
  assign shifted  = bitmap >> diff[IdxW-1:0];

  always_comb begin
    mark_onehot = '0;
    mark_onehot[bit_idx] = 1'b1;
    top_onehot = '0;
    top_onehot[WINDOW_SIZE-1] = 1'b1;
  end

  always_comb begin
    if (ahead) begin
      verdict = VERDICT_FRESH;
    end else if (is_zero) begin
      verdict = VERDICT_ZERO;
    end else if (too_old) begin
      verdict = VERDICT_TOO_OLD;
    end else if (seen) begin
      verdict = VERDICT_REPLAYED;
    end else begin
      verdict = VERDICT_FRESH;
    end
  end

  always_comb begin
    res.verdict  = verdict;
    res.accepted = verdict == VERDICT_FRESH;
    res.update   = (verdict == VERDICT_FRESH) && action;
  end

  // slide forward on a new highest, otherwise set the bit in place
  always_comb begin
    if (ahead) begin
      highest_next = packet_number;
      bitmap_next  = (far_jump ? '0 : shifted) | top_onehot;
    end else begin
      highest_next = highest;
      bitmap_next  = bitmap | mark_onehot;
    end
  end

endmodule

// ===== design/anti_replay_window_core.sv =====
`timescale 1ns / 1ps
// channel | handshake           | payload
// in      | in_valid, in_stall  | action, packet_number
// out     | out_valid, out_stall| accepted, verdict
//
// one item per cycle while out_stall is low; input register, then result register
// the window is judged and updated between the input register and the result register
// rst clears the window, the highest number and both valid flags
// out_stall backs up through the input register into in_stall

module anti_replay_window_core #(
  parameter int WINDOW_SIZE = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    action,
  input  logic [arw_pkg::PnW-1:0] packet_number,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    accepted,
  output logic [1:0]              verdict
);
  import arw_pkg::*;

  logic                   s1_valid;
  logic                   s1_valid_next;
  logic                   s1_action;
  logic [PnW-1:0]         s1_pn;
  logic                   out_valid_next;
  logic                   out_open;
  logic                   s1_adv;
  logic                   in_take;
  logic [PnW-1:0]         highest;
  logic [WINDOW_SIZE-1:0] bitmap;
  logic [PnW-1:0]         highest_next;
  logic [WINDOW_SIZE-1:0] bitmap_next;
  judge_t                 res;

  assign out_open       = !out_valid || !out_stall;
  assign s1_adv         = s1_valid && out_open;
  assign in_stall       = s1_valid && !s1_adv;
  assign in_take        = in_valid && !in_stall;
  assign s1_valid_next  = in_take || (s1_valid && !s1_adv);
  assign out_valid_next = s1_adv || (out_valid && out_stall);

  arw_judge #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_judge (
    .action        (s1_action),
    .packet_number (s1_pn),
    .highest       (highest),
    .bitmap        (bitmap),
    .res           (res),
    .highest_next  (highest_next),
    .bitmap_next   (bitmap_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      highest   <= '0;
      bitmap    <= '0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
      if (s1_adv && res.update) begin
        highest <= highest_next;
        bitmap  <= bitmap_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action <= action;
      s1_pn     <= packet_number;
    end
    if (s1_adv) begin
      accepted <= res.accepted;
      verdict  <= 2'(res.verdict);
    end
  end

  a_highest_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> highest >= $past(highest))
    else $error("highest number went backward");

  a_top_bit_set: assert property (@(posedge clk) disable iff (rst)
    highest != '0 |-> bitmap[WINDOW_SIZE-1])
    else $error("bit of highest number not set");

  a_zero_no_update: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_pn == '0 |=> $stable(highest) && $stable(bitmap))
    else $error("zero number changed the window");

  a_commit_ahead: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_action && s1_pn > highest |=> highest == $past(s1_pn))
    else $error("commit ahead did not move highest number");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import arw_pkg::*;

  localparam int Win = 64;
  localparam logic [63:0] WinMask = (Win >= 64) ? '1 : ((64'd1 << Win) - 64'd1);
  localparam logic ACT_CHECK = 1'b0;
  localparam logic ACT_COMMIT = 1'b1;
  localparam logic [63:0] PnTop = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PnMax = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int NumRandom = 1600;
  localparam int HoldAt = 300;
  localparam int HoldCycles = 48;
  localparam int PauseAt = 800;
  localparam int QuietAt = NumRandom - 200;
  localparam int DrainCycles = 10;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic     accepted;
    verdict_t verdict;
  } window_result_t;

  typedef struct packed {
    logic        commit;
    logic [63:0] pn;
    logic        typed;
    logic        acc;
    verdict_t    vd;
  } pn_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               action;
  logic [PnW-1:0]     packet_number;
  logic               out_valid;
  logic               out_stall;
  logic               accepted;
  logic [1:0]         verdict;

  logic [63:0]        hi_pn = '0;
  logic [63:0]        seen_map = '0;
  window_result_t     verdict_q [$];
  int                 mismatches = 0;
  int                 cycle_count = 0;
  bit                 quiet = 1'b0;
  bit                 burst_off = 1'b0;
  bit                 hold_req = 1'b0;

  pn_row_t dir_rows [0:22] = '{
    '{ACT_CHECK,  64'd0,          1'b1, 1'b0, VERDICT_ZERO},
    '{ACT_COMMIT, 64'd0,          1'b1, 1'b0, VERDICT_ZERO},
    '{ACT_CHECK,  PnMax,          1'b1, 1'b1, VERDICT_FRESH},
    '{ACT_COMMIT, 64'd1,          1'b1, 1'b1, VERDICT_FRESH},
    '{ACT_COMMIT, 64'd1,          1'b1, 1'b0, VERDICT_REPLAYED},
    '{ACT_CHECK,  64'd0,          1'b1, 1'b0, VERDICT_ZERO},
    '{ACT_COMMIT, 64'd100,        1'b1, 1'b1, VERDICT_FRESH},
    '{ACT_CHECK,  64'd36,         1'b1, 1'b0, VERDICT_TOO_OLD},
    '{ACT_COMMIT, 64'd37,         1'b0, 1'b0, VERDICT_FRESH},
    '{ACT_COMMIT, 64'd37,         1'b0, 1'b0, VERDICT_FRESH},
    '{ACT_COMMIT, 64'd90,         1'b0, 1'b0, VERDICT_FRESH},
    '{ACT_COMMIT, 64'd130,        1'b0, 1'b0, VERDICT_FRESH},
    '{ACT_CHECK,  64'd90,         1'b0, 1'b0, VERDICT_FRESH},
    '{ACT_CHECK,  64'd37,         1'b0, 1'b0, VERDICT_FRESH},
    '{ACT_COMMIT, PnTop,          1'b1, 1'b1, VERDICT_FRESH},
    '{ACT_CHECK,  PnTop,          1'b1, 1'b0, VERDICT_REPLAYED},
    '{ACT_COMMIT, PnTop - 64'd1,  1'b0, 1'b0, VERDICT_FRESH},
    '{ACT_CHECK,  PnMax,          1'b1, 1'b1, VERDICT_FRESH},
    '{ACT_CHECK,  PnTop - 64'd64, 1'b1, 1'b0, VERDICT_TOO_OLD},
    '{ACT_COMMIT, PnTop - 64'd63, 1'b0, 1'b0, VERDICT_FRESH},
    '{ACT_COMMIT, PnTop - 64'd63, 1'b0, 1'b0, VERDICT_FRESH},
    '{ACT_CHECK,  64'd1,          1'b1, 1'b0, VERDICT_TOO_OLD},
    '{ACT_COMMIT, PnTop + 64'd1,  1'b0, 1'b0, VERDICT_FRESH}
  };

  anti_replay_window_core #(
    .WINDOW_SIZE(Win)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .packet_number(packet_number),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .accepted(accepted),
    .verdict(verdict)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic window_result_t predict_window(input logic act, input logic [63:0] pn);
    window_result_t r;
    logic [63:0]    lag;
    logic [63:0]    diff;
    if (pn > hi_pn) begin
      r.verdict = VERDICT_FRESH;
    end else if (pn == '0) begin
      r.verdict = VERDICT_ZERO;
    end else begin
      lag = hi_pn - pn;
      if (lag >= 64'(Win)) begin
        r.verdict = VERDICT_TOO_OLD;
      end else if (seen_map[Win - 1 - int'(lag)]) begin
        r.verdict = VERDICT_REPLAYED;
      end else begin
        r.verdict = VERDICT_FRESH;
      end
    end
    r.accepted = (r.verdict == VERDICT_FRESH);
    if (r.accepted && act == ACT_COMMIT) begin
      if (pn > hi_pn) begin
        diff = pn - hi_pn;
        seen_map = (diff >= 64'(Win)) ? '0 : ((seen_map & WinMask) >> diff);
        seen_map[Win - 1] = 1'b1;
        hi_pn = pn;
      end else begin
        seen_map[Win - 1 - int'(hi_pn - pn)] = 1'b1;
        seen_map &= WinMask;
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic act, input logic [63:0] pn, input logic typed,
                           input window_result_t typed_res);
    window_result_t r;
    if (!quiet && !burst_off && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    packet_number <= pn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_window(act, pn);
    verdict_q.push_back(typed ? typed_res : r);
  endtask

  // result side: random stall bursts, one long hold on request
  initial begin
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    window_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none actual accepted %0d verdict %0d",
                 $time, accepted, verdict);
      end else begin
        want = verdict_q.pop_front();
        if (accepted !== want.accepted) begin
          mismatches++;
          $display("%0t: accepted mismatch, expected %0d actual %0d",
                   $time, want.accepted, accepted);
        end
        if (verdict !== want.verdict) begin
          mismatches++;
          $display("%0t: verdict mismatch, expected %0d actual %0d",
                   $time, want.verdict, verdict);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int          kind;
    logic        act;
    logic [63:0] pn;
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= ACT_CHECK;
    packet_number <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r])
      send_item(dir_rows[r].commit, dir_rows[r].pn, dir_rows[r].typed,
                '{dir_rows[r].acc, dir_rows[r].vd});

    for (int i = 0; i < NumRandom; i++) begin
      if (i == HoldAt) begin
        hold_req = 1'b1;
        burst_off = 1'b1;
      end
      if (i == HoldAt + 60)
        burst_off = 1'b0;
      if (i == PauseAt) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0) @(posedge clk);
      end
      if (i == QuietAt)
        quiet = 1'b1;

      kind = $urandom_range(0, 99);
      act = ACT_COMMIT;
      if (kind < 30) begin
        pn = hi_pn + 64'($urandom_range(1, 70));
      end else if (kind < 50) begin
        pn = hi_pn - 64'($urandom_range(0, 63));
      end else if (kind < 65) begin
        act = ACT_CHECK;
        pn = hi_pn + 64'($urandom_range(0, 10)) - 64'($urandom_range(0, 80));
      end else if (kind < 72) begin
        pn = hi_pn - 64'($urandom_range(64, 200));
      end else if (kind < 77) begin
        pn = hi_pn + 64'($urandom_range(64, 5000));
      end else if (kind < 82) begin
        act = logic'($urandom_range(0, 1));
        pn = '0;
      end else begin
        act = ACT_CHECK;
        pn = {$urandom, $urandom};
      end
      send_item(act, pn, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
